// ===== hdl/snfcs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SPI NOR flash sequencer package
// Shared codes, opcodes and the job descriptor passed from front to back.
// ----------------------------------------------------------------------------
package snfcs_pkg;

	localparam logic [2:0] FN_RDID  = 3'd0;
	localparam logic [2:0] FN_READ  = 3'd1;
	localparam logic [2:0] FN_PROG  = 3'd2;
	localparam logic [2:0] FN_PDATA = 3'd3;
	localparam logic [2:0] FN_SE    = 3'd4;
	localparam logic [2:0] FN_CE    = 3'd5;
	localparam logic [2:0] FN_REPLY = 3'd6;

	localparam logic [2:0] K_SPI  = 3'd0;
	localparam logic [2:0] K_REL  = 3'd1;
	localparam logic [2:0] K_HOST = 3'd2;
	localparam logic [2:0] K_ID   = 3'd3;
	localparam logic [2:0] K_DONE = 3'd4;
	localparam logic [2:0] K_REJ  = 3'd5;

	localparam logic [7:0] OP_RDID  = 8'h9F;
	localparam logic [7:0] OP_WREN  = 8'h06;
	localparam logic [7:0] OP_PP    = 8'h02;
	localparam logic [7:0] OP_READ  = 8'h03;
	localparam logic [7:0] OP_SE    = 8'h20;
	localparam logic [7:0] OP_CE    = 8'hC7;
	localparam logic [7:0] OP_RDSR  = 8'h05;
	localparam logic [7:0] DUMMY    = 8'hFF;
	localparam int         BUSY_BIT = 0;

	// Result steps, emitted in ascending order of their index.
	localparam int NUM_STEPS = 13;
	localparam int ST_WREN   = 0;
	localparam int ST_REL1   = 1;
	localparam int ST_OP     = 2;
	localparam int ST_A2     = 3;
	localparam int ST_A1     = 4;
	localparam int ST_A0     = 5;
	localparam int ST_HOST   = 6;
	localparam int ST_REL2   = 7;
	localparam int ST_IDRES  = 8;
	localparam int ST_RDSR   = 9;
	localparam int ST_FF     = 10;
	localparam int ST_DONE   = 11;
	localparam int ST_REJ    = 12;

	localparam int QDEPTH = 4;

	typedef struct packed {
		logic [NUM_STEPS-1:0] steps;
		logic [7:0]           bval;
		logic [23:0]          addr;
		logic [7:0]           maker;
		logic [7:0]           dev_hi;
	} job_t;

endpackage
`default_nettype wire

// ===== hdl/snfcs_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SPI NOR flash sequencer front end
// Accepts transactions, tracks the operation phase and turns each one into
// a job descriptor listing the result steps to emit.
// ----------------------------------------------------------------------------
module snfcs_front #(
	parameter int PAGE_SIZE = 256
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                accept,
	input  wire  [2:0]         func,
	input  wire  [23:0]        address,
	input  wire  [15:0]        length,
	input  wire  [7:0]         data_byte,
	output snfcs_pkg::job_t    job
);
	import snfcs_pkg::*;

	localparam logic [2:0] PH_IDLE = 3'd0;
	localparam logic [2:0] PH_ID1  = 3'd1;
	localparam logic [2:0] PH_ID2  = 3'd2;
	localparam logic [2:0] PH_ID3  = 3'd3;
	localparam logic [2:0] PH_READ = 3'd4;
	localparam logic [2:0] PH_PROG = 3'd5;
	localparam logic [2:0] PH_POLL = 3'd6;

	localparam logic [15:0] PAGE_LEN = 16'(PAGE_SIZE);

	logic [2:0]  phase_q, phase_n;
	logic [15:0] left_q, left_n;
	logic [7:0]  maker_q, maker_n;
	logic [7:0]  dev_hi_q, dev_hi_n;
	logic [15:0] left_dec;
	logic [15:0] prog_len;
	logic        cmd_ok;
	logic        reply_ok;

	assign left_dec = left_q - 16'd1;
	assign prog_len = (length > PAGE_LEN) ? PAGE_LEN : length;
	assign cmd_ok   = (func <= FN_CE) && (func != FN_PDATA) && (phase_q == PH_IDLE);
	assign reply_ok = (func == FN_REPLY) && ((phase_q == PH_ID1) || (phase_q == PH_ID2) ||
		(phase_q == PH_ID3) || (phase_q == PH_READ) || (phase_q == PH_POLL));

	always_comb begin
		job.steps  = '0;
		job.bval   = data_byte;
		job.addr   = address;
		job.maker  = maker_q;
		job.dev_hi = dev_hi_q;
		phase_n    = phase_q;
		left_n     = left_q;
		maker_n    = maker_q;
		dev_hi_n   = dev_hi_q;
		if (cmd_ok) begin
			case (func)
				FN_RDID: begin
					job.steps[ST_OP] = 1'b1;
					job.steps[ST_FF] = 1'b1;
					job.bval         = OP_RDID;
					phase_n          = PH_ID1;
				end
				FN_READ: begin
					job.steps[ST_OP] = 1'b1;
					job.steps[ST_A2] = 1'b1;
					job.steps[ST_A1] = 1'b1;
					job.steps[ST_A0] = 1'b1;
					job.bval         = OP_READ;
					if (length == 16'd0) begin
						job.steps[ST_REL2] = 1'b1;
						job.steps[ST_DONE] = 1'b1;
					end else begin
						job.steps[ST_FF] = 1'b1;
						left_n           = length;
						phase_n          = PH_READ;
					end
				end
				FN_PROG: begin
					job.steps[ST_WREN] = 1'b1;
					job.steps[ST_REL1] = 1'b1;
					job.steps[ST_OP]   = 1'b1;
					job.steps[ST_A2]   = 1'b1;
					job.steps[ST_A1]   = 1'b1;
					job.steps[ST_A0]   = 1'b1;
					job.bval           = OP_PP;
					if (prog_len == 16'd0) begin
						job.steps[ST_REL2] = 1'b1;
						job.steps[ST_RDSR] = 1'b1;
						job.steps[ST_FF]   = 1'b1;
						phase_n            = PH_POLL;
					end else begin
						left_n  = prog_len;
						phase_n = PH_PROG;
					end
				end
				FN_SE: begin
					job.steps[ST_WREN] = 1'b1;
					job.steps[ST_REL1] = 1'b1;
					job.steps[ST_OP]   = 1'b1;
					job.steps[ST_A2]   = 1'b1;
					job.steps[ST_A1]   = 1'b1;
					job.steps[ST_A0]   = 1'b1;
					job.steps[ST_REL2] = 1'b1;
					job.steps[ST_RDSR] = 1'b1;
					job.steps[ST_FF]   = 1'b1;
					job.bval           = OP_SE;
					phase_n            = PH_POLL;
				end
				default: begin
					job.steps[ST_WREN] = 1'b1;
					job.steps[ST_REL1] = 1'b1;
					job.steps[ST_OP]   = 1'b1;
					job.steps[ST_REL2] = 1'b1;
					job.steps[ST_RDSR] = 1'b1;
					job.steps[ST_FF]   = 1'b1;
					job.bval           = OP_CE;
					phase_n            = PH_POLL;
				end
			endcase
		end else if ((func == FN_PDATA) && (phase_q == PH_PROG)) begin
			job.steps[ST_OP] = 1'b1;
			left_n           = left_dec;
			if (left_dec == 16'd0) begin
				job.steps[ST_REL2] = 1'b1;
				job.steps[ST_RDSR] = 1'b1;
				job.steps[ST_FF]   = 1'b1;
				phase_n            = PH_POLL;
			end
		end else if (reply_ok) begin
			case (phase_q)
				PH_ID1: begin
					job.steps[ST_FF] = 1'b1;
					maker_n          = data_byte;
					phase_n          = PH_ID2;
				end
				PH_ID2: begin
					job.steps[ST_FF] = 1'b1;
					dev_hi_n         = data_byte;
					phase_n          = PH_ID3;
				end
				PH_ID3: begin
					job.steps[ST_REL2]  = 1'b1;
					job.steps[ST_IDRES] = 1'b1;
					job.steps[ST_DONE]  = 1'b1;
					phase_n             = PH_IDLE;
				end
				PH_READ: begin
					job.steps[ST_HOST] = 1'b1;
					left_n             = left_dec;
					if (left_dec == 16'd0) begin
						job.steps[ST_REL2] = 1'b1;
						job.steps[ST_DONE] = 1'b1;
						phase_n            = PH_IDLE;
					end else begin
						job.steps[ST_FF] = 1'b1;
					end
				end
				default: begin
					if (data_byte[BUSY_BIT]) begin
						job.steps[ST_FF] = 1'b1;
					end else begin
						job.steps[ST_REL2] = 1'b1;
						job.steps[ST_DONE] = 1'b1;
						phase_n            = PH_IDLE;
					end
				end
			endcase
		end else begin
			job.steps[ST_REJ] = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			left_q   <= '0;
			maker_q  <= '0;
			dev_hi_q <= '0;
		end else if (accept) begin
			phase_q  <= phase_n;
			left_q   <= left_n;
			maker_q  <= maker_n;
			dev_hi_q <= dev_hi_n;
		end
	end

endmodule
`default_nettype wire

// ===== hdl/snfcs_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SPI NOR flash sequencer job queue
// A short first-in first-out queue of job descriptors between front and back.
// ----------------------------------------------------------------------------
module snfcs_fifo (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               push,
	input  snfcs_pkg::job_t   push_job,
	output logic              full,
	input  wire               pop,
	output snfcs_pkg::job_t   pop_job,
	output logic              empty
);
	import snfcs_pkg::*;

	localparam int PW = $clog2(QDEPTH);
	localparam int CW = $clog2(QDEPTH + 1);

	job_t          slot_q [QDEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full    = (count_q == CW'(QDEPTH));
	assign empty   = (count_q == '0);
	assign pop_job = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule
`default_nettype wire

// ===== hdl/snfcs_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SPI NOR flash sequencer back end
// Walks the steps of each job in order and presents one result per cycle,
// while out_stall is low, from an output register.
// ----------------------------------------------------------------------------
module snfcs_back (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               q_empty,
	input  snfcs_pkg::job_t   q_job,
	output logic              q_pop,
	output logic              out_valid,
	input  wire               out_stall,
	output logic [2:0]        kind,
	output logic [7:0]        spi_byte,
	output logic              want_reply,
	output logic [7:0]        host_byte,
	output logic [7:0]        maker_id,
	output logic [15:0]       device_id,
	output logic              last
);
	import snfcs_pkg::*;

	localparam int SW = $clog2(NUM_STEPS);

	job_t                 cur_q;
	logic                 out_valid_q;
	logic                 adv;
	logic                 emit;
	logic [NUM_STEPS-1:0] rest;
	logic [SW-1:0]        sel;
	logic [2:0]           r_kind;
	logic [7:0]           r_spi;
	logic                 r_want;
	logic [7:0]           r_host;
	logic [7:0]           r_maker;
	logic [15:0]          r_dev;

	assign adv       = !out_valid_q || !out_stall;
	assign emit      = adv && (cur_q.steps != '0);
	assign rest      = cur_q.steps & (cur_q.steps - NUM_STEPS'(1));
	assign q_pop     = !q_empty && ((cur_q.steps == '0) || (emit && (rest == '0)));
	assign out_valid = out_valid_q;

	always_comb begin
		sel = '0;
		for (int i = NUM_STEPS - 1; i >= 0; i--) begin
			if (cur_q.steps[i]) begin
				sel = SW'(i);
			end
		end
	end

	always_comb begin
		r_kind  = K_SPI;
		r_spi   = '0;
		r_want  = 1'b0;
		r_host  = '0;
		r_maker = '0;
		r_dev   = '0;
		unique case (sel)
			SW'(ST_WREN):  r_spi = OP_WREN;
			SW'(ST_REL1):  r_kind = K_REL;
			SW'(ST_OP):    r_spi = cur_q.bval;
			SW'(ST_A2):    r_spi = cur_q.addr[23:16];
			SW'(ST_A1):    r_spi = cur_q.addr[15:8];
			SW'(ST_A0):    r_spi = cur_q.addr[7:0];
			SW'(ST_HOST): begin
				r_kind = K_HOST;
				r_host = cur_q.bval;
			end
			SW'(ST_REL2):  r_kind = K_REL;
			SW'(ST_IDRES): begin
				r_kind  = K_ID;
				r_maker = cur_q.maker;
				r_dev   = {cur_q.dev_hi, cur_q.bval};
			end
			SW'(ST_RDSR):  r_spi = OP_RDSR;
			SW'(ST_FF): begin
				r_spi  = DUMMY;
				r_want = 1'b1;
			end
			SW'(ST_DONE):  r_kind = K_DONE;
			default:       r_kind = K_REJ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			cur_q       <= '0;
		end else begin
			if (adv) begin
				out_valid_q <= emit;
			end
			if (q_pop) begin
				cur_q <= q_job;
			end else if (emit) begin
				cur_q.steps <= rest;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			kind       <= r_kind;
			spi_byte   <= r_spi;
			want_reply <= r_want;
			host_byte  <= r_host;
			maker_id   <= r_maker;
			device_id  <= r_dev;
			last       <= (rest == '0);
		end
	end

endmodule
`default_nettype wire

// ===== hdl/spi_nor_flash_command_sequencer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SPI NOR flash command sequencer
// Turns host commands and flash reply bytes into SPI byte, chip-select and
// status results.
// ----------------------------------------------------------------------------
// An input transaction is accepted in any cycle in which the four-entry job
// queue has room, so transactions may follow each other back to back. Each
// transaction expands into one to nine results, which leave the output
// register at one per cycle when out_stall is low: a data or reply byte
// yields one to four results, a command up to nine. Each transaction goes
// through the queue and the current-job register to the output register.
// The flash status is polled with opcode 0x05 followed by 0xFF bytes, each
// of which is to be returned as a reply transaction.
module spi_nor_flash_command_sequencer #(
	parameter int PAGE_SIZE = 256
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         in_valid,
	output logic        in_stall,
	input  wire  [2:0]  func,
	input  wire  [23:0] address,
	input  wire  [15:0] length,
	input  wire  [7:0]  data_byte,
	output logic        out_valid,
	input  wire         out_stall,
	output logic [2:0]  kind,
	output logic [7:0]  spi_byte,
	output logic        want_reply,
	output logic [7:0]  host_byte,
	output logic [7:0]  maker_id,
	output logic [15:0] device_id,
	output logic        last
);
	import snfcs_pkg::*;

	job_t new_job;
	job_t head_job;
	logic q_full;
	logic q_empty;
	logic q_pop;
	logic accept;

	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;

	snfcs_front #(
		.PAGE_SIZE(PAGE_SIZE)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.func      (func),
		.address   (address),
		.length    (length),
		.data_byte (data_byte),
		.job       (new_job)
	);

	snfcs_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (accept),
		.push_job (new_job),
		.full     (q_full),
		.pop      (q_pop),
		.pop_job  (head_job),
		.empty    (q_empty)
	);

	snfcs_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_empty    (q_empty),
		.q_job      (head_job),
		.q_pop      (q_pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.kind       (kind),
		.spi_byte   (spi_byte),
		.want_reply (want_reply),
		.host_byte  (host_byte),
		.maker_id   (maker_id),
		.device_id  (device_id),
		.last       (last)
	);

endmodule
`default_nettype wire

// ===== hdl/snfcs_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SPI NOR flash sequencer port checker
// Concurrent assertions on the top level's ports, bound to every instance.
// ----------------------------------------------------------------------------
module snfcs_checker (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         out_valid,
	input  wire         out_stall,
	input  wire  [2:0]  kind,
	input  wire  [7:0]  spi_byte,
	input  wire         want_reply,
	input  wire  [7:0]  host_byte,
	input  wire  [15:0] device_id,
	input  wire         last
);
	import snfcs_pkg::*;

	a_valid_held : assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result transaction withdrawn while stalled");

	a_payload_held : assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(kind) && $stable(spi_byte) && $stable(last))
		else $error("result transaction changed while stalled");

	a_reply_poll : assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && want_reply |-> (kind == K_SPI) && (spi_byte == DUMMY))
		else $error("reply requested on a result that is not a dummy byte");

	a_id_then_done : assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && (kind == K_ID) |-> !last ##1 out_valid && (kind == K_DONE)
		|| !out_valid)
		else $error("id result not followed by done");

	a_quiet_fields : assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind != K_SPI) |-> !want_reply && (spi_byte == 8'd0)
		&& ((kind == K_HOST) || (host_byte == 8'd0))
		&& ((kind == K_ID) || (device_id == 16'd0)))
		else $error("unused result field not zero");

endmodule

bind spi_nor_flash_command_sequencer snfcs_checker u_snfcs_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.kind       (kind),
	.spi_byte   (spi_byte),
	.want_reply (want_reply),
	.host_byte  (host_byte),
	.device_id  (device_id),
	.last       (last)
);
`default_nettype wire

// ===== dv/spi_nor_flash_command_sequencer_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SPI NOR flash command sequencer testbench
// Drives host commands, program data and flash reply bytes into the sequencer
// and checks every result against a transaction-level prediction of the
// command flow. Directed tests cover each command, the corner cases and the
// rejections, then a long random run plays the flash side of well-formed
// operations with noise mixed in. Both handshakes are disturbed at random.
// ----------------------------------------------------------------------------
module spi_nor_flash_command_sequencer_test;
	import snfcs_pkg::*;

	localparam int         PAGE_BYTES   = 256;
	localparam int         RANDOM_ITEMS = 120;
	localparam int         QUIET_ITEMS  = 30;
	localparam logic [2:0] FN_UNUSED    = 3'd7;

	typedef enum logic [2:0] {
		SQ_IDLE, SQ_ID1, SQ_ID2, SQ_ID3, SQ_READ, SQ_PROG, SQ_POLL
	} seq_phase_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [7:0]  spi_byte;
		logic        want_reply;
		logic [7:0]  host_byte;
		logic [7:0]  maker_id;
		logic [15:0] device_id;
		logic        last;
	} flash_action_t;

	logic        clk        = 1'b0;
	logic        arst_n     = 1'b0;
	logic        in_valid   = 1'b0;
	logic [2:0]  func       = '0;
	logic [23:0] address    = '0;
	logic [15:0] length     = '0;
	logic [7:0]  data_byte  = '0;
	logic        out_stall  = 1'b0;
	wire         in_stall;
	wire         out_valid;
	wire  [2:0]  kind;
	wire  [7:0]  spi_byte;
	wire         want_reply;
	wire  [7:0]  host_byte;
	wire  [7:0]  maker_id;
	wire  [15:0] device_id;
	wire         last;

	seq_phase_t    seq_phase  = SQ_IDLE;
	logic [15:0]   left_bytes = '0;
	logic [7:0]    maker_q    = '0;
	logic [7:0]    dev_hi_q   = '0;
	flash_action_t held_action;
	bit            held_valid = 1'b0;
	flash_action_t pending_actions[$];

	int  mismatch_count = 0;
	int  items_sent     = 0;
	int  stall_left     = 0;
	bit  idle_on        = 1'b1;
	bit  stall_on       = 1'b1;

	spi_nor_flash_command_sequencer #(
		.PAGE_SIZE(PAGE_BYTES)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.func(func),
		.address(address),
		.length(length),
		.data_byte(data_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.kind(kind),
		.spi_byte(spi_byte),
		.want_reply(want_reply),
		.host_byte(host_byte),
		.maker_id(maker_id),
		.device_id(device_id),
		.last(last)
	);

	always #1 clk = ~clk;

	// The newest action is held back so that the final one of a transaction can
	// be marked as last before it is queued.
	function automatic void add_action(logic [2:0] k, logic [7:0] sb, logic wr, logic [7:0] hb,
			logic [7:0] mk, logic [15:0] dv);
		if (held_valid) begin
			pending_actions.push_back(held_action);
		end
		held_action.kind       = k;
		held_action.spi_byte   = sb;
		held_action.want_reply = wr;
		held_action.host_byte  = hb;
		held_action.maker_id   = mk;
		held_action.device_id  = dv;
		held_action.last       = 1'b0;
		held_valid             = 1'b1;
	endfunction

	function automatic void add_byte(logic [7:0] b, logic wr);
		add_action(K_SPI, b, wr, 8'h00, 8'h00, 16'h0000);
	endfunction

	function automatic void add_mark(logic [2:0] k);
		add_action(k, 8'h00, 1'b0, 8'h00, 8'h00, 16'h0000);
	endfunction

	function automatic void add_address(logic [23:0] a);
		add_byte(a[23:16], 1'b0);
		add_byte(a[15:8], 1'b0);
		add_byte(a[7:0], 1'b0);
	endfunction

	function automatic void begin_status_poll();
		add_mark(K_REL);
		add_byte(OP_RDSR, 1'b0);
		add_byte(DUMMY, 1'b1);
		seq_phase = SQ_POLL;
	endfunction

	function automatic void finish_operation();
		add_mark(K_REL);
		add_mark(K_DONE);
		seq_phase = SQ_IDLE;
	endfunction

	function automatic void expand_transaction(logic [2:0] f, logic [23:0] a, logic [15:0] n,
			logic [7:0] b);
		logic [15:0] count;
		count = n;
		if (f != FN_PDATA && f <= FN_CE && seq_phase == SQ_IDLE) begin
			case (f)
				FN_RDID: begin
					add_byte(OP_RDID, 1'b0);
					add_byte(DUMMY, 1'b1);
					seq_phase = SQ_ID1;
				end
				FN_READ: begin
					add_byte(OP_READ, 1'b0);
					add_address(a);
					if (n == 16'd0) begin
						add_mark(K_REL);
						add_mark(K_DONE);
					end else begin
						left_bytes = n;
						add_byte(DUMMY, 1'b1);
						seq_phase = SQ_READ;
					end
				end
				FN_PROG: begin
					if (count > PAGE_BYTES) begin
						count = 16'(PAGE_BYTES);
					end
					add_byte(OP_WREN, 1'b0);
					add_mark(K_REL);
					add_byte(OP_PP, 1'b0);
					add_address(a);
					if (count == 16'd0) begin
						begin_status_poll();
					end else begin
						left_bytes = count;
						seq_phase  = SQ_PROG;
					end
				end
				FN_SE: begin
					add_byte(OP_WREN, 1'b0);
					add_mark(K_REL);
					add_byte(OP_SE, 1'b0);
					add_address(a);
					begin_status_poll();
				end
				default: begin
					add_byte(OP_WREN, 1'b0);
					add_mark(K_REL);
					add_byte(OP_CE, 1'b0);
					begin_status_poll();
				end
			endcase
		end else if (f == FN_PDATA && seq_phase == SQ_PROG) begin
			add_byte(b, 1'b0);
			left_bytes = left_bytes - 16'd1;
			if (left_bytes == 16'd0) begin
				begin_status_poll();
			end
		end else if (f == FN_REPLY && seq_phase != SQ_IDLE && seq_phase != SQ_PROG) begin
			case (seq_phase)
				SQ_ID1: begin
					maker_q = b;
					add_byte(DUMMY, 1'b1);
					seq_phase = SQ_ID2;
				end
				SQ_ID2: begin
					dev_hi_q = b;
					add_byte(DUMMY, 1'b1);
					seq_phase = SQ_ID3;
				end
				SQ_ID3: begin
					add_mark(K_REL);
					add_action(K_ID, 8'h00, 1'b0, 8'h00, maker_q, {dev_hi_q, b});
					add_mark(K_DONE);
					seq_phase = SQ_IDLE;
				end
				SQ_READ: begin
					add_action(K_HOST, 8'h00, 1'b0, b, 8'h00, 16'h0000);
					left_bytes = left_bytes - 16'd1;
					if (left_bytes == 16'd0) begin
						finish_operation();
					end else begin
						add_byte(DUMMY, 1'b1);
					end
				end
				default: begin
					if (b[BUSY_BIT]) begin
						add_byte(DUMMY, 1'b1);
					end else begin
						finish_operation();
					end
				end
			endcase
		end else begin
			add_mark(K_REJ);
		end
		held_action.last = 1'b1;
		pending_actions.push_back(held_action);
		held_valid = 1'b0;
	endfunction

	task automatic report_mismatch(string what, int unsigned got, int unsigned wanted);
		if (mismatch_count < 100) begin
			$display("%0t: %s mismatch: got 0x%0h, expected 0x%0h", $realtime, what, got, wanted);
		end
		mismatch_count++;
	endtask

	task automatic check_action();
		flash_action_t exp_a;
		if (pending_actions.size() == 0) begin
			report_mismatch("unexpected result kind", 32'(kind), 0);
		end else begin
			exp_a = pending_actions.pop_front();
			if (kind !== exp_a.kind)
				report_mismatch("kind", 32'(kind), 32'(exp_a.kind));
			if (spi_byte !== exp_a.spi_byte)
				report_mismatch("spi_byte", 32'(spi_byte), 32'(exp_a.spi_byte));
			if (want_reply !== exp_a.want_reply)
				report_mismatch("want_reply", 32'(want_reply), 32'(exp_a.want_reply));
			if (host_byte !== exp_a.host_byte)
				report_mismatch("host_byte", 32'(host_byte), 32'(exp_a.host_byte));
			if (maker_id !== exp_a.maker_id)
				report_mismatch("maker_id", 32'(maker_id), 32'(exp_a.maker_id));
			if (device_id !== exp_a.device_id)
				report_mismatch("device_id", 32'(device_id), 32'(exp_a.device_id));
			if (last !== exp_a.last)
				report_mismatch("last", 32'(last), 32'(exp_a.last));
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
			check_action();
		end
	end

	always @(posedge clk) begin
		if (stall_left != 0) begin
			out_stall  <= 1'b1;
			stall_left <= stall_left - 1;
		end else if (stall_on && arst_n && $urandom_range(0, 6) == 0) begin
			out_stall  <= 1'b1;
			stall_left <= $urandom_range(0, 2);
		end else begin
			out_stall <= 1'b0;
		end
	end

	// Called at a rising edge; returns at the edge where the transaction is
	// accepted, with valid still high so that the next one may follow directly.
	task automatic send_item(logic [2:0] f, logic [23:0] a, logic [15:0] n, logic [7:0] b);
		int gap;
		if (idle_on && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 3);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		func      <= f;
		address   <= a;
		length    <= n;
		data_byte <= b;
		@(posedge clk);
		while (in_stall !== 1'b0) @(posedge clk);
		expand_transaction(f, a, n, b);
		items_sent++;
	endtask

	task automatic send_noise();
		logic [2:0]  f;
		logic [15:0] n;
		f = 3'($urandom_range(0, 7));
		n = 16'($urandom);
		if (seq_phase == SQ_IDLE && (f == FN_READ || f == FN_PROG)) begin
			n = {12'h000, n[3:0]};
		end
		send_item(f, 24'($urandom), n, 8'($urandom));
	endtask

	task automatic play_flash_side();
		int         polls;
		logic [7:0] reply;
		polls = 0;
		while (seq_phase != SQ_IDLE) begin
			reply = 8'($urandom);
			if ($urandom_range(0, 9) == 0) begin
				send_noise();
			end else if (seq_phase == SQ_PROG) begin
				send_item(FN_PDATA, 24'($urandom), 16'($urandom), reply);
			end else begin
				if (seq_phase == SQ_POLL) begin
					polls++;
					reply[BUSY_BIT] = (polls <= 3 && $urandom_range(0, 2) != 0);
				end
				send_item(FN_REPLY, 24'($urandom), 16'($urandom), reply);
			end
		end
	endtask

	task automatic test_read_id();
		send_item(FN_RDID, 24'hFFFFFF, 16'hFFFF, 8'hFF);
		send_item(FN_REPLY, 24'h000000, 16'h0000, 8'h00);
		send_item(FN_REPLY, 24'hFFFFFF, 16'hFFFF, 8'hFF);
		send_item(FN_REPLY, 24'h5A5A5A, 16'hA5A5, 8'h5A);
	endtask

	task automatic test_read();
		send_item(FN_READ, 24'hFFFFFF, 16'h0000, 8'h00);
		send_item(FN_READ, 24'h000000, 16'h0002, 8'hFF);
		send_item(FN_REPLY, 24'h000000, 16'h0000, 8'hFF);
		send_item(FN_REPLY, 24'h000000, 16'h0000, 8'h00);
	endtask

	task automatic test_program();
		send_item(FN_PROG, 24'h123456, 16'h0000, 8'h00);
		send_item(FN_REPLY, 24'h000000, 16'h0000, 8'h01);
		send_item(FN_REPLY, 24'h000000, 16'h0000, 8'hFE);
		send_item(FN_PROG, 24'h000100, 16'h0002, 8'h00);
		send_item(FN_PDATA, 24'h000000, 16'h0000, 8'h00);
		send_item(FN_PDATA, 24'h000000, 16'h0000, 8'hFF);
		send_item(FN_REPLY, 24'h000000, 16'h0000, 8'h00);
	endtask

	task automatic test_erase();
		send_item(FN_SE, 24'hABCDEF, 16'h0000, 8'h00);
		send_item(FN_REPLY, 24'h000000, 16'h0000, 8'hFF);
		send_item(FN_REPLY, 24'h000000, 16'h0000, 8'h02);
		send_item(FN_CE, 24'h000000, 16'h0000, 8'h00);
		send_item(FN_REPLY, 24'h000000, 16'h0000, 8'h00);
	endtask

	// A transaction that does not fit the current phase is refused and leaves
	// the operation in progress untouched.
	task automatic test_rejects();
		send_item(FN_PDATA, 24'h000000, 16'h0000, 8'h11);
		send_item(FN_REPLY, 24'h000000, 16'h0000, 8'h22);
		send_item(FN_UNUSED, 24'hFFFFFF, 16'hFFFF, 8'hFF);
		send_item(FN_PROG, 24'h000040, 16'h0001, 8'h00);
		send_item(FN_REPLY, 24'h000000, 16'h0000, 8'h00);
		send_item(FN_SE, 24'h000000, 16'h0000, 8'h00);
		send_item(FN_PDATA, 24'h000000, 16'h0000, 8'h3C);
		send_item(FN_RDID, 24'h000000, 16'h0000, 8'h00);
		send_item(FN_REPLY, 24'h000000, 16'h0000, 8'h00);
	endtask

	task automatic test_page_limit();
		send_item(FN_PROG, 24'hFFFF00, 16'hFFFF, 8'h00);
		for (int i = 0; i < PAGE_BYTES; i++) begin
			send_item(FN_PDATA, 24'($urandom), 16'($urandom), 8'($urandom));
		end
		send_item(FN_REPLY, 24'h000000, 16'h0000, 8'h01);
		send_item(FN_REPLY, 24'h000000, 16'h0000, 8'h00);
	endtask

	task automatic test_random();
		int          stop_at;
		logic [2:0]  f;
		logic [15:0] n;
		stop_at = items_sent + RANDOM_ITEMS;
		while (items_sent < stop_at) begin
			if (items_sent >= stop_at - QUIET_ITEMS) begin
				idle_on  = 1'b0;
				stall_on = 1'b0;
			end
			if ($urandom_range(0, 5) == 0) begin
				send_noise();
			end else begin
				case ($urandom_range(0, 4))
					0: f = FN_RDID;
					1: f = FN_READ;
					2: f = FN_PROG;
					3: f = FN_SE;
					default: f = FN_CE;
				endcase
				n = 16'($urandom_range(0, 8));
				if ($urandom_range(0, 9) == 0) begin
					n = 16'($urandom_range(9, 40));
				end
				send_item(f, 24'($urandom), n, 8'($urandom));
			end
			play_flash_side();
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_read_id();
		test_read();
		test_program();
		test_erase();
		test_rejects();
		test_page_limit();
		test_random();
		in_valid <= 1'b0;
		while (pending_actions.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("spi_nor_flash_command_sequencer test passed");
		end else begin
			$display("spi_nor_flash_command_sequencer test failed");
		end
		$finish;
	end

	initial begin
		#1_000_000;
		$display("spi_nor_flash_command_sequencer test failed");
		$finish;
	end

endmodule
